FILE: design/i2c_codec_register_file_defines.svh
// Assertion macros shared by the register file RTL.
`ifndef I2C_CODEC_REGISTER_FILE_DEFINES_SVH
`define I2C_CODEC_REGISTER_FILE_DEFINES_SVH

`ifndef SYNTHESIS

`define I2CC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define I2CC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define I2CC_ASSERT_IMP(label, clk, rst, ante, cons)

`define I2CC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/i2cc_pkg.sv
// Types, constants and rate decoding for the codec register file.
package i2cc_pkg;

   localparam int REG_COUNT_DEFAULT = 21140;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ADDR_DEVICE_ID = 16'h000f;
   localparam logic [15:0] ADDR_RATE_CTRL = 16'h001b;
   localparam logic [15:0] DEVICE_ID_VALUE = 16'h6243;
   localparam logic [15:0] RATE_CTRL_RESET = 16'h0010;
   localparam logic [15:0] RATE_SR_MASK = 16'h0007;
   localparam int RATE_INT_BIT = 4;

   localparam logic [16:0] RATE_48000 = 17'd48000;
   localparam logic [16:0] RATE_44100 = 17'd44100;
   localparam logic [16:0] RATE_32000 = 17'd32000;
   localparam logic [16:0] RATE_24000 = 17'd24000;
   localparam logic [16:0] RATE_22050 = 17'd22050;
   localparam logic [16:0] RATE_16000 = 17'd16000;
   localparam logic [16:0] RATE_12000 = 17'd12000;
   localparam logic [16:0] RATE_8000 = 17'd8000;
   localparam logic [16:0] RATE_96000 = 17'd96000;
   localparam logic [16:0] RATE_88200 = 17'd88200;
   localparam logic [16:0] RATE_UNKNOWN = 17'd0;

   typedef enum logic [1:0] {
      ACT_START_WRITE = 2'd0,
      ACT_START_READ  = 2'd1,
      ACT_BYTE_WRITE  = 2'd2,
      ACT_BYTE_READ   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_WSTART  = 3'd0,
      OP_RSTART  = 3'd1,
      OP_ADDR_HI = 3'd2,
      OP_ADDR_LO = 3'd3,
      OP_VAL_HI  = 3'd4,
      OP_VAL_LO  = 3'd5,
      OP_RD_HI   = 3'd6,
      OP_RD_LO   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      WPH_ADDR_HI = 2'd0,
      WPH_ADDR_LO = 2'd1,
      WPH_VAL_HI  = 2'd2,
      WPH_VAL_LO  = 2'd3
   } wphase_type;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_RDWAIT = 2'd2
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
   } entry_type;

   function automatic logic [16:0] decode_rate(input logic [15:0] ctl);
      logic [2:0] sr;
      logic       whole_rate;
      logic [16:0] rate;
      sr = 3'(ctl & RATE_SR_MASK);
      whole_rate = ctl[RATE_INT_BIT];
      case (sr)
         3'd0: rate = whole_rate ? RATE_48000 : RATE_44100;
         3'd1: rate = RATE_32000;
         3'd2: rate = whole_rate ? RATE_24000 : RATE_22050;
         3'd3: rate = RATE_16000;
         3'd4: rate = RATE_12000;
         3'd5: rate = RATE_8000;
         3'd6: rate = whole_rate ? RATE_96000 : RATE_88200;
         default: rate = RATE_UNKNOWN;
      endcase
      return rate;
   endfunction

endpackage

FILE: design/i2cc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/i2cc_front.sv
// Front end: accepts bus events and classifies them by transfer phase.
module i2cc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_write_byte,
   input  logic               q_full,
   input  logic               clearing,
   output logic               q_push,
   output i2cc_pkg::entry_type q_entry
);

   i2cc_pkg::wphase_type wphase_ff, wphase_in;
   logic                 rphase_ff, rphase_in;
   i2cc_pkg::op_type     op;

   assign busy = q_full | clearing;
   assign q_push = start & ~busy;

   always_comb begin
      wphase_in = wphase_ff;
      rphase_in = rphase_ff;
      op = i2cc_pkg::OP_WSTART;
      case (i2cc_pkg::action_type'(req_action))
         i2cc_pkg::ACT_START_WRITE: begin
            op = i2cc_pkg::OP_WSTART;
            wphase_in = i2cc_pkg::WPH_ADDR_HI;
         end
         i2cc_pkg::ACT_START_READ: begin
            op = i2cc_pkg::OP_RSTART;
            rphase_in = 1'b0;
         end
         i2cc_pkg::ACT_BYTE_WRITE: begin
            case (wphase_ff)
               i2cc_pkg::WPH_ADDR_HI: begin
                  op = i2cc_pkg::OP_ADDR_HI;
                  wphase_in = i2cc_pkg::WPH_ADDR_LO;
               end
               i2cc_pkg::WPH_ADDR_LO: begin
                  op = i2cc_pkg::OP_ADDR_LO;
                  wphase_in = i2cc_pkg::WPH_VAL_HI;
               end
               i2cc_pkg::WPH_VAL_HI: begin
                  op = i2cc_pkg::OP_VAL_HI;
                  wphase_in = i2cc_pkg::WPH_VAL_LO;
               end
               default: begin
                  op = i2cc_pkg::OP_VAL_LO;
                  wphase_in = i2cc_pkg::WPH_VAL_HI;
               end
            endcase
         end
         default: begin
            op = rphase_ff ? i2cc_pkg::OP_RD_LO : i2cc_pkg::OP_RD_HI;
            rphase_in = ~rphase_ff;
         end
      endcase
   end

   assign q_entry.op = op;
   assign q_entry.data = req_write_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         wphase_ff <= i2cc_pkg::WPH_ADDR_HI;
         rphase_ff <= 1'b0;
      end else if (q_push) begin
         wphase_ff <= wphase_in;
         rphase_ff <= rphase_in;
      end
   end

endmodule

FILE: design/i2cc_queue.sv
// Short item queue between front and back ends.
module i2cc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cc_pkg::entry_type push_entry,
   input  logic                pop,
   output i2cc_pkg::entry_type head,
   output logic                not_empty,
   output logic                full
);

   localparam int PW = $clog2(i2cc_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(i2cc_pkg::QUEUE_DEPTH + 1);

   i2cc_pkg::entry_type slot_ff [i2cc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CW'(i2cc_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(i2cc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(i2cc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/i2cc_back.sv
// Back end: clears the store, executes classified items, drives results.
`include "i2c_codec_register_file_defines.svh"

module i2cc_back #(
   parameter int REG_COUNT = i2cc_pkg::REG_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  i2cc_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_read_byte,
   output logic [16:0]         rsp_sample_rate_hz,
   output logic                rsp_rate_update
);

   localparam int AW = $clog2(REG_COUNT);

   i2cc_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [15:0]   ptr_ff, ptr_in;
   logic [7:0]    addr_hi_ff, addr_hi_in;
   logic [7:0]    val_hi_ff, val_hi_in;
   logic [16:0]   rate_ff, rate_in;
   logic          rd_lo_ff, rd_lo_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    byte_ff, byte_in;
   logic          upd_ff, upd_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]   ram_wdata, ram_rdata;
   logic          in_range;
   logic [15:0]   ptr_inc;

   assign in_range = ({1'b0, ptr_ff} < 17'(REG_COUNT));
   assign ptr_inc = ptr_ff + 16'd1;

   i2cc_ram #(
      .WIDTH(16),
      .DEPTH(REG_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ptr_in = ptr_ff;
      addr_hi_in = addr_hi_ff;
      val_hi_in = val_hi_ff;
      rate_in = rate_ff;
      rd_lo_in = rd_lo_ff;
      rd_ok_in = rd_ok_ff;
      strobe_in = 1'b0;
      byte_in = 8'd0;
      upd_in = 1'b0;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = ptr_ff[AW-1:0];
      ram_raddr = ptr_ff[AW-1:0];
      ram_wdata = {val_hi_ff, q_head.data};
      case (state_ff)
         i2cc_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == AW'(i2cc_pkg::ADDR_DEVICE_ID)) begin
               ram_wdata = i2cc_pkg::DEVICE_ID_VALUE;
            end else if (clr_ff == AW'(i2cc_pkg::ADDR_RATE_CTRL)) begin
               ram_wdata = i2cc_pkg::RATE_CTRL_RESET;
            end else begin
               ram_wdata = 16'd0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(REG_COUNT - 1)) begin
               state_in = i2cc_pkg::ST_IDLE;
            end
         end
         i2cc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_head.op)
                  i2cc_pkg::OP_ADDR_HI: begin
                     addr_hi_in = q_head.data;
                     strobe_in = 1'b1;
                  end
                  i2cc_pkg::OP_ADDR_LO: begin
                     ptr_in = {addr_hi_ff, q_head.data};
                     strobe_in = 1'b1;
                  end
                  i2cc_pkg::OP_VAL_HI: begin
                     val_hi_in = q_head.data;
                     strobe_in = 1'b1;
                  end
                  i2cc_pkg::OP_VAL_LO: begin
                     if (in_range) begin
                        ram_we = 1'b1;
                        if (ptr_ff == i2cc_pkg::ADDR_RATE_CTRL) begin
                           rate_in = i2cc_pkg::decode_rate(ram_wdata);
                           upd_in = 1'b1;
                        end
                     end
                     ptr_in = ptr_inc;
                     strobe_in = 1'b1;
                  end
                  i2cc_pkg::OP_RD_HI, i2cc_pkg::OP_RD_LO: begin
                     ram_re = 1'b1;
                     rd_lo_in = (q_head.op == i2cc_pkg::OP_RD_LO);
                     rd_ok_in = in_range;
                     state_in = i2cc_pkg::ST_RDWAIT;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         i2cc_pkg::ST_RDWAIT: begin
            strobe_in = 1'b1;
            if (rd_ok_ff) begin
               byte_in = rd_lo_ff ? ram_rdata[7:0] : ram_rdata[15:8];
            end
            if (rd_lo_ff) begin
               ptr_in = ptr_inc;
            end
            state_in = i2cc_pkg::ST_IDLE;
         end
         default: begin
            state_in = i2cc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2cc_pkg::ST_CLEAR;
         clr_ff <= '0;
         ptr_ff <= 16'd0;
         addr_hi_ff <= 8'd0;
         val_hi_ff <= 8'd0;
         rate_ff <= i2cc_pkg::decode_rate(i2cc_pkg::RATE_CTRL_RESET);
         strobe_ff <= 1'b0;
         upd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ptr_ff <= ptr_in;
         addr_hi_ff <= addr_hi_in;
         val_hi_ff <= val_hi_in;
         rate_ff <= rate_in;
         strobe_ff <= strobe_in;
         upd_ff <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_lo_ff <= rd_lo_in;
      rd_ok_ff <= rd_ok_in;
      byte_ff <= byte_in;
   end

   assign clearing = (state_ff == i2cc_pkg::ST_CLEAR);
   assign rsp_strobe = strobe_ff;
   assign rsp_read_byte = byte_ff;
   assign rsp_sample_rate_hz = rate_ff;
   assign rsp_rate_update = upd_ff;

   `I2CC_ASSERT_NXT(a_read_completes, clock, reset, state_ff == i2cc_pkg::ST_RDWAIT, strobe_ff)
   `I2CC_ASSERT_IMP(a_update_strobed, clock, reset, upd_ff, strobe_ff)
   `I2CC_ASSERT_IMP(a_no_pop_in_clear, clock, reset, state_ff == i2cc_pkg::ST_CLEAR, !q_pop)
   `I2CC_ASSERT_IMP(a_write_in_range, clock, reset, ram_we && state_ff != i2cc_pkg::ST_CLEAR, in_range)

endmodule

FILE: design/i2c_codec_register_file.sv
// Top level of the codec register file: front end, item queue, back end.
//
// Channel   Ports                                         Handshake
// request   req_action, req_write_byte                    start high, busy low
// response  rsp_read_byte, rsp_sample_rate_hz,            rsp_strobe, one cycle
//           rsp_rate_update
//
// An item is queued in the accept cycle; byte reads add a read-wait state in the back
// end, set by the registered read port of the store memory.
// The registered result strobe follows the pop from the queue, or the read-wait state.
// After reset busy stays high while the store is cleared and the device ID and
// rate-control defaults are loaded.
// Busy rises when the two-entry queue is full; the receiver cannot stall results.
module i2c_codec_register_file #(
   parameter int REG_COUNT = i2cc_pkg::REG_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_byte,
   output logic [16:0] rsp_sample_rate_hz,
   output logic        rsp_rate_update
);

   i2cc_pkg::entry_type push_entry, head_entry;
   logic push, pop, q_full, q_valid, clearing;

   i2cc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_write_byte (req_write_byte),
      .q_full         (q_full),
      .clearing       (clearing),
      .q_push         (push),
      .q_entry        (push_entry)
   );

   i2cc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head_entry),
      .not_empty  (q_valid),
      .full       (q_full)
   );

   i2cc_back #(
      .REG_COUNT(REG_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_head             (head_entry),
      .q_pop              (pop),
      .clearing           (clearing),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_sample_rate_hz (rsp_sample_rate_hz),
      .rsp_rate_update    (rsp_rate_update)
   );

endmodule
